// ===== sv/bmp8_pkg.sv =====
// Shared types and constants for the 8-bit palettized BMP stream decoder.
// Used by bmp8_parse, bmp8_emit and bmp8_stream_decoder; depends on nothing.
`default_nettype none

package bmp8_pkg;

  localparam int DEF_MAX_WIDTH   = 4096;
  localparam int DEF_MAX_HEIGHT  = 4096;
  localparam int DEF_PAL_ENTRIES = 256;

  localparam int HDR_LAST     = 53;
  localparam int MIN_INFO     = 40;
  localparam int FULL_PALETTE = 256;
  localparam int PAL_BASE     = 14;
  localparam int BPP_8        = 8;

  localparam int OFF_SIG    = 0;
  localparam int OFF_DATA   = 10;
  localparam int OFF_INFO   = 14;
  localparam int OFF_WIDTH  = 18;
  localparam int OFF_HEIGHT = 22;
  localparam int OFF_BPP    = 28;
  localparam int OFF_COMP   = 30;
  localparam int OFF_PCNT   = 46;
  localparam int OFF_PEND   = 50;

  localparam logic [7:0] SIG_B = 8'h42;
  localparam logic [7:0] SIG_M = 8'h4D;

  localparam int COORD_W    = 12;
  localparam int COLOR_W    = 32;
  localparam int PAL_W      = 24;
  localparam int OUT_DATA_W = 2 * COORD_W + COLOR_W;

  localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 32'hFF00_0000;
  localparam logic [7:0]         ALPHA_BYTE   = 8'hFF;

  typedef enum logic [2:0] {
    ST_PIXEL       = 3'd0,
    ST_COMPLETE    = 3'd1,
    ST_NOT_BMP     = 3'd2,
    ST_SMALL_HDR   = 3'd3,
    ST_UNSUPPORTED = 3'd4,
    ST_TOO_LARGE   = 3'd5,
    ST_BAD_LAYOUT  = 3'd6,
    ST_TRUNCATED   = 3'd7
  } status_t;

  typedef struct packed {
    logic                is_pix;
    logic                use_pal;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    status_t             status;
    logic                done;
  } item_t;

endpackage

`default_nettype wire

// ===== sv/bmp8_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// Holds the decoder palette; depends on nothing.
`default_nettype none

module bmp8_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/bmp8_parse.sv =====
// Byte parser: header capture and checks, palette loading, pixel position tracking.
// Depends on bmp8_pkg; drives the palette RAM ports and the result stage.
`default_nettype none

module bmp8_parse #(
  parameter int MAX_WIDTH       = bmp8_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT      = bmp8_pkg::DEF_MAX_HEIGHT,
  parameter int PALETTE_ENTRIES = bmp8_pkg::DEF_PAL_ENTRIES
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 take,
  input  wire logic [7:0]                           in_byte,
  input  wire logic                                 in_sof,
  input  wire logic                                 in_eof,
  output logic                                      res_valid,
  output bmp8_pkg::item_t                           res,
  output logic                                      ram_we,
  output logic [$clog2(PALETTE_ENTRIES)-1:0]        ram_waddr,
  output logic [bmp8_pkg::PAL_W-1:0]                ram_wdata,
  output logic                                      ram_re,
  output logic [$clog2(PALETTE_ENTRIES)-1:0]        ram_raddr
);

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam int EW = $clog2(PALETTE_ENTRIES + 1);
  localparam int CW = $clog2(MAX_WIDTH + 4);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_PALETTE = 5'b00010,
    PH_PIXELS  = 5'b00100,
    PH_DONE    = 5'b01000,
    PH_ERROR   = 5'b10000
  } phase_t;

  function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [5:0] hpos,
                                           input logic [5:0] base, input logic [7:0] b);
    logic [31:0] w;
    logic [5:0]  rel;
    w   = word;
    rel = hpos - base;
    if (hpos >= base && rel < 6'd4) begin
      w[8*rel[1:0] +: 8] = b;
    end
    return w;
  endfunction

  phase_t        phase_r, phase_nxt;
  logic [31:0]   pos_r, pos_nxt;
  logic [EW-1:0] ent_r, ent_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [HW-1:0] row_r, row_nxt;

  logic [15:0]   sig_r, sig_nxt;
  logic [31:0]   dstart_r, dstart_nxt;
  logic [31:0]   info_r, info_nxt;
  logic [31:0]   wraw_r, wraw_nxt;
  logic [31:0]   hraw_r, hraw_nxt;
  logic [15:0]   bpp_r, bpp_nxt;
  logic [31:0]   comp_r, comp_nxt;
  logic [31:0]   pcnt_r, pcnt_nxt;
  logic [32:0]   pbeg_r, pbeg_nxt;
  logic [33:0]   pend_r, pend_nxt;
  logic [CW-1:0] width_r, width_nxt;
  logic [CW-1:0] rowb_r, rowb_nxt;
  logic [HW-1:0] height_r, height_nxt;
  logic          bu_r, bu_nxt;
  logic [7:0]    pb_r, pb_nxt;
  logic [7:0]    pg_r, pg_nxt;

  phase_t           cur_phase;
  logic [31:0]      cur_pos;
  logic [5:0]       hpos;
  logic [31:0]      mag;
  logic [8:0]       cnt;
  logic [CW-1:0]    wsum;
  bmp8_pkg::status_t hdr_st;
  logic             hdr_bad;
  logic             pix_go;
  logic             in_pal;
  logic [9:0]       off;
  logic [CW-1:0]    col1;
  logic             wrap;
  logic             done;
  logic [HW-1:0]    ypos;
  logic             hit;

  assign mag  = hraw_r[31] ? (32'd0 - hraw_r) : hraw_r;
  assign cnt  = (pcnt_r == 32'd0 || pcnt_r > 32'(bmp8_pkg::FULL_PALETTE)) ?
                9'(bmp8_pkg::FULL_PALETTE) : pcnt_r[8:0];
  assign wsum = CW'(wraw_r) + CW'(3);

  always_comb begin
    hdr_bad = 1'b1;
    hdr_st  = bmp8_pkg::ST_PIXEL;
    priority if (sig_r != {bmp8_pkg::SIG_M, bmp8_pkg::SIG_B}) begin
      hdr_st = bmp8_pkg::ST_NOT_BMP;
    end else if (info_r < 32'(bmp8_pkg::MIN_INFO)) begin
      hdr_st = bmp8_pkg::ST_SMALL_HDR;
    end else if (bpp_r != 16'(bmp8_pkg::BPP_8) || comp_r != 32'd0 || wraw_r == 32'd0 ||
                 wraw_r[31] || hraw_r == 32'd0) begin
      hdr_st = bmp8_pkg::ST_UNSUPPORTED;
    end else if (wraw_r > 32'(MAX_WIDTH) || mag > 32'(MAX_HEIGHT)) begin
      hdr_st = bmp8_pkg::ST_TOO_LARGE;
    end else if (34'(dstart_r) < pend_r) begin
      hdr_st = bmp8_pkg::ST_BAD_LAYOUT;
    end else begin
      hdr_bad = 1'b0;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    ent_nxt    = ent_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    sig_nxt    = sig_r;
    dstart_nxt = dstart_r;
    info_nxt   = info_r;
    wraw_nxt   = wraw_r;
    hraw_nxt   = hraw_r;
    bpp_nxt    = bpp_r;
    comp_nxt   = comp_r;
    pcnt_nxt   = pcnt_r;
    pbeg_nxt   = pbeg_r;
    pend_nxt   = pend_r;
    width_nxt  = width_r;
    rowb_nxt   = rowb_r;
    height_nxt = height_r;
    bu_nxt     = bu_r;
    pb_nxt     = pb_r;
    pg_nxt     = pg_r;

    cur_phase = in_sof ? PH_HEADER : phase_r;
    cur_pos   = in_sof ? 32'd0 : pos_r;
    hpos      = cur_pos[5:0];
    pix_go    = 1'b0;
    in_pal    = (pos_r >= pbeg_r[31:0]) && (pos_r < pend_r[31:0]);
    off       = pos_r[9:0] - pbeg_r[9:0];
    col1      = col_r + CW'(1);
    wrap      = col1 >= rowb_r;
    done      = wrap && (HW'(row_r + HW'(1)) >= height_r);
    ypos      = bu_r ? HW'(height_r - HW'(1) - row_r) : row_r;
    hit       = 9'(in_byte) < 9'(ent_r);

    res_valid      = 1'b0;
    res.is_pix     = 1'b0;
    res.use_pal    = 1'b0;
    res.x          = '0;
    res.y          = '0;
    res.status     = bmp8_pkg::ST_PIXEL;
    res.done       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = off[AW+1:2];
    ram_wdata      = {in_byte, pg_r, pb_r};
    ram_re         = 1'b0;
    ram_raddr      = in_byte[AW-1:0];

    if (take) begin
      if (in_sof) begin
        phase_nxt = PH_HEADER;
        pos_nxt   = 32'd0;
        ent_nxt   = '0;
        col_nxt   = '0;
        row_nxt   = '0;
      end
      unique case (cur_phase)
        PH_HEADER: begin
          pos_nxt    = cur_pos + 32'd1;
          sig_nxt    = 16'(put_byte({16'd0, sig_r}, hpos, 6'(bmp8_pkg::OFF_SIG), in_byte));
          dstart_nxt = put_byte(dstart_r, hpos, 6'(bmp8_pkg::OFF_DATA), in_byte);
          info_nxt   = put_byte(info_r, hpos, 6'(bmp8_pkg::OFF_INFO), in_byte);
          wraw_nxt   = put_byte(wraw_r, hpos, 6'(bmp8_pkg::OFF_WIDTH), in_byte);
          hraw_nxt   = put_byte(hraw_r, hpos, 6'(bmp8_pkg::OFF_HEIGHT), in_byte);
          bpp_nxt    = 16'(put_byte({16'd0, bpp_r}, hpos, 6'(bmp8_pkg::OFF_BPP), in_byte));
          comp_nxt   = put_byte(comp_r, hpos, 6'(bmp8_pkg::OFF_COMP), in_byte);
          pcnt_nxt   = put_byte(pcnt_r, hpos, 6'(bmp8_pkg::OFF_PCNT), in_byte);
          if (hpos == 6'(bmp8_pkg::OFF_WIDTH)) begin
            pbeg_nxt = 33'(info_r) + 33'(bmp8_pkg::PAL_BASE);
          end
          if (hpos == 6'(bmp8_pkg::OFF_PEND)) begin
            pend_nxt = 34'(pbeg_r) + 34'({cnt, 2'b00});
          end
          if (hpos == 6'(bmp8_pkg::HDR_LAST)) begin
            if (hdr_bad) begin
              phase_nxt  = PH_ERROR;
              res_valid  = 1'b1;
              res.status = hdr_st;
            end else begin
              phase_nxt  = PH_PALETTE;
              width_nxt  = CW'(wraw_r);
              rowb_nxt   = {wsum[CW-1:2], 2'b00};
              height_nxt = HW'(mag);
              bu_nxt     = ~hraw_r[31];
            end
          end else if (in_eof) begin
            phase_nxt  = PH_ERROR;
            res_valid  = 1'b1;
            res.status = bmp8_pkg::ST_NOT_BMP;
          end
        end
        PH_PALETTE: begin
          if (pos_r >= dstart_r) begin
            pix_go = 1'b1;
          end else begin
            pos_nxt = pos_r + 32'd1;
            if (in_pal && (9'(off[9:2]) < 9'(PALETTE_ENTRIES))) begin
              unique case (off[1:0])
                2'd0: pb_nxt = in_byte;
                2'd1: pg_nxt = in_byte;
                2'd2: ram_we = 1'b1;
                2'd3: ent_nxt = EW'(9'(off[9:2]) + 9'd1);
                default: ;
              endcase
            end
          end
        end
        PH_PIXELS: pix_go = 1'b1;
        PH_DONE, PH_ERROR: ;
        default: ;
      endcase

      if (pix_go) begin
        col_nxt   = wrap ? '0 : col1;
        row_nxt   = wrap ? HW'(row_r + HW'(1)) : row_r;
        phase_nxt = done ? PH_DONE : PH_PIXELS;
        if (col_r < width_r) begin
          res_valid   = 1'b1;
          res.is_pix  = 1'b1;
          res.use_pal = hit;
          res.x       = bmp8_pkg::COORD_W'(col_r);
          res.y       = bmp8_pkg::COORD_W'(ypos);
          res.done    = done;
          ram_re      = hit;
        end else if (done) begin
          res_valid  = 1'b1;
          res.status = bmp8_pkg::ST_COMPLETE;
          res.done   = 1'b1;
        end
      end

      if (in_eof && (phase_nxt == PH_PALETTE || phase_nxt == PH_PIXELS)) begin
        phase_nxt   = PH_ERROR;
        res_valid   = 1'b1;
        res.is_pix  = 1'b0;
        res.use_pal = 1'b0;
        res.x       = '0;
        res.y       = '0;
        res.status  = bmp8_pkg::ST_TRUNCATED;
        res.done    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
      ent_r   <= '0;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      ent_r   <= ent_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sig_r    <= sig_nxt;
    dstart_r <= dstart_nxt;
    info_r   <= info_nxt;
    wraw_r   <= wraw_nxt;
    hraw_r   <= hraw_nxt;
    bpp_r    <= bpp_nxt;
    comp_r   <= comp_nxt;
    pcnt_r   <= pcnt_nxt;
    pbeg_r   <= pbeg_nxt;
    pend_r   <= pend_nxt;
    width_r  <= width_nxt;
    rowb_r   <= rowb_nxt;
    height_r <= height_nxt;
    bu_r     <= bu_nxt;
    pb_r     <= pb_nxt;
    pg_r     <= pg_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/bmp8_emit.sv =====
// Result stage: pairs each item with its registered palette read, then forms the ARGB result.
// Depends on bmp8_pkg; holds the output register toward the result channel.
`default_nettype none

module bmp8_emit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              push,
  input  wire bmp8_pkg::item_t                   push_item,
  input  wire logic [bmp8_pkg::PAL_W-1:0]        pal_rdata,
  output logic                                   can_take,
  output logic                                   out_valid,
  output logic [bmp8_pkg::OUT_DATA_W-1:0]        out_data,
  output logic [2:0]                             out_status,
  output logic                                   out_last,
  input  wire logic                              out_ready
);

  logic                           s1_valid_r;
  bmp8_pkg::item_t                s1_item_r;
  logic                           out_valid_r;
  logic [bmp8_pkg::OUT_DATA_W-1:0] data_r, data_nxt;
  logic [2:0]                     status_r;
  logic                           last_r;
  logic                           s1_adv;
  logic [bmp8_pkg::COLOR_W-1:0]   color;

  assign s1_adv   = ~out_valid_r | out_ready;
  assign can_take = ~s1_valid_r | s1_adv;

  always_comb begin
    if (!s1_item_r.is_pix) begin
      color = '0;
    end else if (s1_item_r.use_pal) begin
      color = {bmp8_pkg::ALPHA_BYTE, pal_rdata};
    end else begin
      color = bmp8_pkg::ALPHA_OPAQUE;
    end
    data_nxt = {color, s1_item_r.y, s1_item_r.x};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (can_take) begin
        s1_valid_r <= push;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_take) begin
      s1_item_r <= push_item;
    end
    if (s1_adv && s1_valid_r) begin
      data_r   <= data_nxt;
      status_r <= s1_item_r.status;
      last_r   <= s1_item_r.done;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = data_r;
  assign out_status = status_r;
  assign out_last   = last_r;

endmodule

`default_nettype wire

// ===== sv/bmp8_stream_decoder.sv =====
// Top level of the 8-bit palettized BMP stream decoder.
// Depends on bmp8_pkg, bmp8_ram, bmp8_parse and bmp8_emit.
//
// Channel  Dir  tdata (low bit up)                        tuser          tlast
// in_      in   [7:0] data_byte                           start_of_file  end_of_file
// out_     out  [11:0] x, [23:12] y, [55:24] color_argb   [2:0] status   image_done
//
// One byte is accepted per cycle while the result stage can take it; results are registered.
// The palette memory read port serves the pixel lookup of each pixel byte.
// Reset clears the parse control and the result valid flags only; a palette entry is read
// only after the current file has loaded it, so the palette memory needs no clearing pass.
// A stalled result holds the result stage, and input is then held off.
`default_nettype none

module bmp8_stream_decoder #(
  parameter int MAX_WIDTH       = bmp8_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT      = bmp8_pkg::DEF_MAX_HEIGHT,
  parameter int PALETTE_ENTRIES = bmp8_pkg::DEF_PAL_ENTRIES
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [7:0]                        in_tdata,   // data_byte
  input  wire logic                              in_tuser,   // start_of_file
  input  wire logic                              in_tlast,   // end_of_file
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [bmp8_pkg::OUT_DATA_W-1:0]        out_tdata,  // pixel_x, pixel_y, color_argb
  output logic [2:0]                             out_tuser,  // status
  output logic                                   out_tlast   // image_done
);

  localparam int AW = $clog2(PALETTE_ENTRIES);

  logic                          take;
  logic                          res_valid;
  bmp8_pkg::item_t               res;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [bmp8_pkg::PAL_W-1:0]    ram_wdata;
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;
  logic [bmp8_pkg::PAL_W-1:0]    ram_rdata;
  logic                          can_take;

  assign in_tready = can_take;
  assign take      = in_tvalid & can_take;

  bmp8_parse #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_HEIGHT      (MAX_HEIGHT),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .in_byte   (in_tdata),
    .in_sof    (in_tuser),
    .in_eof    (in_tlast),
    .res_valid (res_valid),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  bmp8_ram #(
    .WIDTH (bmp8_pkg::PAL_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bmp8_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_item  (res),
    .pal_rdata  (ram_rdata),
    .can_take   (can_take),
    .out_valid  (out_tvalid),
    .out_data   (out_tdata),
    .out_status (out_tuser),
    .out_last   (out_tlast),
    .out_ready  (out_tready)
  );

`ifndef SYNTHESIS
  a_ram_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("palette write and pixel read in the same cycle");

  a_complete_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == bmp8_pkg::ST_COMPLETE |-> out_tlast)
    else $error("completion result without image_done");

  a_error_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == bmp8_pkg::ST_NOT_BMP || out_tuser == bmp8_pkg::ST_SMALL_HDR ||
                   out_tuser == bmp8_pkg::ST_UNSUPPORTED || out_tuser == bmp8_pkg::ST_TOO_LARGE ||
                   out_tuser == bmp8_pkg::ST_BAD_LAYOUT || out_tuser == bmp8_pkg::ST_TRUNCATED)
    |-> !out_tlast)
    else $error("error result marked as image_done");

  a_read_only_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> take && res_valid)
    else $error("palette read without an accepted pixel byte");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for bmp8_stream_decoder: streams BMP files byte by byte
// with random stalls on both sides and checks every pixel and status it reports.
// Depends on bmp8_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module tb_top;

  localparam int STALL_LIMIT  = 2000;
  localparam int LONG_HOLD    = 400;
  localparam int RANDOM_BYTES = 100;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [bmp8_pkg::COORD_W-1:0] x;
    logic [bmp8_pkg::COORD_W-1:0] y;
    logic [bmp8_pkg::COLOR_W-1:0] color;
    bmp8_pkg::status_t            status;
    logic                         done;
  } decoded_t;

  class bmp8_decode_tracker;
    typedef enum logic [4:0] {
      PARSE_HEADER  = 5'b00001,
      PARSE_PALETTE = 5'b00010,
      PARSE_PIXELS  = 5'b00100,
      PARSE_DONE    = 5'b01000,
      PARSE_ERROR   = 5'b10000
    } phase_t;

    decoded_t    decoded_q[$];
    int          mismatches;
    phase_t      phase;
    logic [31:0] pos, data_off, info_len, width, height, loaded, col, row;
    logic        bottom_up;
    logic [7:0]  hdr[54];
    logic [23:0] palette[256];

    function new();
      mismatches = 0;
      foreach (palette[i]) palette[i] = '0;
      foreach (hdr[i]) hdr[i] = '0;
      restart();
    endfunction

    function void restart();
      pos = 0;
      phase = PARSE_HEADER;
      data_off = 0;
      info_len = 0;
      width = 0;
      height = 0;
      bottom_up = 1'b0;
      loaded = 0;
      col = 0;
      row = 0;
    endfunction

    function logic [31:0] hdr_word(int off);
      return {hdr[off+3], hdr[off+2], hdr[off+1], hdr[off]};
    endfunction

    function longint unsigned pal_first();
      return 64'(bmp8_pkg::PAL_BASE) + 64'(info_len);
    endfunction

    function longint unsigned pal_last();
      logic [31:0] n;
      n = hdr_word(bmp8_pkg::OFF_PCNT);
      if (n == 0 || n > bmp8_pkg::FULL_PALETTE) n = bmp8_pkg::FULL_PALETTE;
      return pal_first() + 64'(n) * 4;
    endfunction

    // ST_PIXEL here means the header was accepted.
    function bmp8_pkg::status_t header_verdict();
      logic [31:0] w, hraw, mag;
      if (hdr[0] != bmp8_pkg::SIG_B || hdr[1] != bmp8_pkg::SIG_M) return bmp8_pkg::ST_NOT_BMP;
      data_off = hdr_word(bmp8_pkg::OFF_DATA);
      info_len = hdr_word(bmp8_pkg::OFF_INFO);
      if (info_len < bmp8_pkg::MIN_INFO) return bmp8_pkg::ST_SMALL_HDR;
      w = hdr_word(bmp8_pkg::OFF_WIDTH);
      hraw = hdr_word(bmp8_pkg::OFF_HEIGHT);
      if ({hdr[bmp8_pkg::OFF_BPP+1], hdr[bmp8_pkg::OFF_BPP]} != 16'(bmp8_pkg::BPP_8) ||
          hdr_word(bmp8_pkg::OFF_COMP) != 0 || w == 0 || w[31] || hraw == 0)
        return bmp8_pkg::ST_UNSUPPORTED;
      mag = hraw[31] ? -hraw : hraw;
      if (w > bmp8_pkg::DEF_MAX_WIDTH || mag > bmp8_pkg::DEF_MAX_HEIGHT)
        return bmp8_pkg::ST_TOO_LARGE;
      if (64'(data_off) < pal_last()) return bmp8_pkg::ST_BAD_LAYOUT;
      width = w;
      height = mag;
      bottom_up = !hraw[31];
      return bmp8_pkg::ST_PIXEL;
    endfunction

    function void take_byte(logic [7:0] b, logic sof, logic eof);
      decoded_t          res;
      logic              got;
      logic [31:0]       row_len, x, y;
      longint unsigned   off;
      bmp8_pkg::status_t verdict;
      got = 1'b0;
      res = '0;
      if (sof) restart();
      if (phase == PARSE_HEADER) begin
        if (pos < 54) hdr[pos] = b;
        pos++;
        if (pos >= 54) begin
          verdict = header_verdict();
          if (verdict != bmp8_pkg::ST_PIXEL) begin
            res.status = verdict;
            got = 1'b1;
            phase = PARSE_ERROR;
          end else begin
            phase = PARSE_PALETTE;
          end
        end else if (eof) begin
          res.status = bmp8_pkg::ST_NOT_BMP;
          got = 1'b1;
          phase = PARSE_ERROR;
        end
      end else if (phase == PARSE_PALETTE && pos >= data_off) begin
        phase = PARSE_PIXELS;
      end else if (phase == PARSE_PALETTE) begin
        if (64'(pos) >= pal_first() && 64'(pos) < pal_last()) begin
          off = 64'(pos) - pal_first();
          if (off[1:0] != 2'd3) palette[off[9:2]][8*off[1:0] +: 8] = b;
          else loaded = 32'(off[9:2]) + 1;
        end
        pos++;
      end

      if (phase == PARSE_PIXELS) begin
        row_len = (width + 3) & ~32'd3;
        x = col;
        y = bottom_up ? height - 1 - row : row;
        col++;
        if (col >= row_len) begin
          col = 0;
          row++;
        end
        if (x < width) begin
          res.x = x[bmp8_pkg::COORD_W-1:0];
          res.y = y[bmp8_pkg::COORD_W-1:0];
          res.color = bmp8_pkg::ALPHA_OPAQUE;
          if (32'(b) < loaded) res.color[bmp8_pkg::PAL_W-1:0] = palette[b];
          res.status = bmp8_pkg::ST_PIXEL;
          res.done = (row >= height);
          got = 1'b1;
        end else if (row >= height) begin
          res.status = bmp8_pkg::ST_COMPLETE;
          res.done = 1'b1;
          got = 1'b1;
        end
        if (row >= height) phase = PARSE_DONE;
      end

      // An early end overrides a pixel decoded from the same byte.
      if (eof && (phase == PARSE_PALETTE || phase == PARSE_PIXELS)) begin
        res = '0;
        res.status = bmp8_pkg::ST_TRUNCATED;
        got = 1'b1;
        phase = PARSE_ERROR;
      end
      if (got) decoded_q.push_back(res);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] seen);
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, seen);
      mismatches++;
    endfunction

    function void match_result(logic [bmp8_pkg::OUT_DATA_W-1:0] data, logic [2:0] st,
                               logic done);
      decoded_t want;
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual x=%0d y=%0d color=%h st=%0d done=%0b",
                 $time, data[11:0], data[23:12], data[55:24], st, done);
        mismatches++;
        return;
      end
      want = decoded_q.pop_front();
      if (data[11:0] != want.x) report("pixel_x", want.x, data[11:0]);
      if (data[23:12] != want.y) report("pixel_y", want.y, data[23:12]);
      if (data[55:24] != want.color) report("color_argb", want.color, data[55:24]);
      if (st != want.status) report("status", want.status, st);
      if (done != want.done) report("image_done", want.done, done);
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [7:0]                      in_tdata;
  logic                            in_tuser;
  logic                            in_tlast;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [bmp8_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [2:0]                      out_tuser;
  logic                            out_tlast;
  int                              cyc = 0;
  logic                            hold_asked;
  logic                            hold_done;
  bmp8_decode_tracker              tracker;

  bmp8_stream_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cyc <= cyc + 1;

  function automatic bit calm_window();
    return (cyc % 800) >= 500;
  endfunction

  function automatic void put32(ref byte_q_t f, input int off, input logic [31:0] v);
    for (int k = 0; k < 4; k++) f[off+k] = v[8*k +: 8];
  endfunction

  function automatic void trim(ref byte_q_t f, input int n);
    while (f.size() > n) void'(f.pop_back());
  endfunction

  // Builds a complete file: header, info filler, palette, gap and pixel array.
  function automatic void build_image(ref byte_q_t f, input int unsigned w,
                                      input logic [31:0] hraw, input int unsigned pcnt,
                                      input int unsigned info_len, input int unsigned gap);
    int unsigned entries, mag, row_len;
    f.delete();
    entries = (pcnt == 0 || pcnt > bmp8_pkg::FULL_PALETTE) ? bmp8_pkg::FULL_PALETTE : pcnt;
    mag = hraw[31] ? -hraw : hraw;
    row_len = (w + 3) & ~32'd3;
    repeat (54) f.push_back(8'($urandom));
    f[0] = bmp8_pkg::SIG_B;
    f[1] = bmp8_pkg::SIG_M;
    put32(f, bmp8_pkg::OFF_DATA, bmp8_pkg::PAL_BASE + info_len + 4 * entries + gap);
    put32(f, bmp8_pkg::OFF_INFO, info_len);
    put32(f, bmp8_pkg::OFF_WIDTH, w);
    put32(f, bmp8_pkg::OFF_HEIGHT, hraw);
    f[bmp8_pkg::OFF_BPP] = 8'(bmp8_pkg::BPP_8);
    f[bmp8_pkg::OFF_BPP+1] = 8'h00;
    put32(f, bmp8_pkg::OFF_COMP, 32'd0);
    put32(f, bmp8_pkg::OFF_PCNT, pcnt);
    while (f.size() < bmp8_pkg::PAL_BASE + info_len) f.push_back(8'($urandom));
    repeat (4 * entries + gap) f.push_back(8'($urandom));
    repeat (mag * row_len) begin
      if ($urandom_range(0, 3) != 0) f.push_back(8'($urandom_range(0, entries - 1)));
      else f.push_back(8'($urandom));
    end
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic sof, input logic eof);
    @(negedge clk);
    while (!calm_window() && $urandom_range(0, 99) < 19) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = b;
    in_tuser = sof;
    in_tlast = eof;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.take_byte(b, sof, eof);
  endtask

  task automatic send_file(input byte_q_t f, input logic sof, input logic eof);
    foreach (f[i]) push_byte(f[i], sof && i == 0, eof && i == f.size() - 1);
  endtask

  task automatic header_fault(input int field, input logic [31:0] v, input int field2,
                              input logic [31:0] v2, input int len);
    byte_q_t f;
    build_image(f, 2, 32'd1, 2, 40, 0);
    put32(f, field, v);
    put32(f, field2, v2);
    trim(f, len);
    send_file(f, 1'b1, 1'b1);
  endtask

  initial begin
    out_tready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asked && !hold_done) begin
        out_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
      end
      out_tready = calm_window() || ($urandom_range(0, 99) >= 19);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.match_result(out_tdata, out_tuser, out_tlast);
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("bmp8_stream_decoder regression: fail");
        $finish;
      end
    end
  end

  initial begin
    byte_q_t     img;
    int          n, kind, pick, sent;
    logic [31:0] hraw;
    tracker = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    hold_asked = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The first file comes without a start mark and ends on row padding.
    build_image(img, 2, 32'd2, 4, 40, 0);
    send_file(img, 1'b0, 1'b1);
    // Top-down rows end on a pixel while the receiver holds off for a long stretch.
    // A two-entry palette leaves the fully random indices mostly outside it.
    hold_asked = 1'b1;
    build_image(img, 4, -32'd3, 2, 40, 1);
    send_file(img, 1'b1, 1'b1);
    // A count of zero is read as 256 entries, and the widest row passes the size check.
    build_image(img, bmp8_pkg::DEF_MAX_WIDTH, -32'd1, 0, 40, 0);
    trim(img, 58);
    send_file(img, 1'b1, 1'b1);
    // A count above 256 is capped, and a longer info header moves the palette.
    build_image(img, 1, 32'(bmp8_pkg::DEF_MAX_HEIGHT), 300, 44, 0);
    trim(img, 60);
    send_file(img, 1'b1, 1'b1);

    header_fault(bmp8_pkg::OFF_DATA, 32'd61, bmp8_pkg::OFF_DATA, 32'd61, 54);
    header_fault(bmp8_pkg::OFF_SIG, 32'h0000_4D42, bmp8_pkg::OFF_SIG, 32'h0000_4D42, 20);

    sent = 0;
    while (sent < RANDOM_BYTES) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        hraw = $urandom_range(1, 4);
        if ($urandom_range(0, 1) != 0) hraw = -hraw;
        build_image(img, $urandom_range(1, 9), hraw,
                    ($urandom_range(0, 32) == 0) ? 0 : $urandom_range(1, 8),
                    40 + 4 * $urandom_range(0, 3), $urandom_range(0, 5));
        n = $urandom_range(0, 99);
        if (n < 60) begin
          send_file(img, 1'b1, 1'b1);
        end else if (n < 75) begin
          send_file(img, 1'b1, 1'b0);
          repeat ($urandom_range(1, 6)) push_byte(8'($urandom), 1'b0, $urandom_range(0, 1));
        end else begin
          trim(img, $urandom_range(54, img.size() - 1));
          send_file(img, 1'b1, $urandom_range(0, 1));
        end
        sent += img.size();
      end else if (kind < 85) begin
        build_image(img, $urandom_range(1, 6), $urandom_range(1, 3), $urandom_range(1, 4), 40, 0);
        pick = $urandom_range(0, 2);
        unique case ($urandom_range(0, 6))
          0: img[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
          1: put32(img, bmp8_pkg::OFF_INFO, $urandom_range(0, bmp8_pkg::MIN_INFO - 1));
          2: img[bmp8_pkg::OFF_BPP + $urandom_range(0, 1)] = 8'($urandom);
          3: put32(img, bmp8_pkg::OFF_COMP, $urandom_range(1, 255));
          4: put32(img, bmp8_pkg::OFF_WIDTH, pick == 0 ? 32'd0 :
                   pick == 1 ? (32'h8000_0000 | $urandom) : 32'($urandom_range(4097, 70000)));
          5: put32(img, bmp8_pkg::OFF_HEIGHT, pick == 0 ? 32'd0 :
                   pick == 1 ? -32'($urandom_range(4097, 70000)) :
                   32'($urandom_range(4097, 70000)));
          default: put32(img, bmp8_pkg::OFF_DATA, $urandom_range(0, 57));
        endcase
        trim(img, $urandom_range(20, img.size()));
        send_file(img, 1'b1, 1'b1);
        sent += img.size();
      end else begin
        n = $urandom_range(5, 60);
        for (int i = 0; i < n; i++) push_byte(8'($urandom), i == 0, $urandom_range(0, 15) == 0);
        sent += n;
      end
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    while (tracker.decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("bmp8_stream_decoder regression: pass");
    end else begin
      $display("bmp8_stream_decoder regression: fail");
    end
    $finish;
  end
endmodule

// ===== bmp8_stream_decoder.f =====
sv/bmp8_pkg.sv
sv/bmp8_ram.sv
sv/bmp8_parse.sv
sv/bmp8_emit.sv
sv/bmp8_stream_decoder.sv
tb/tb_top.sv
